@@ src/stack_allocator_with_rollback_log_top_macros.svh @@
// Assertion macros for the checker file of the stack allocator.
`ifndef STACK_ALLOCATOR_WITH_ROLLBACK_LOG_TOP_MACROS_SVH
`define STACK_ALLOCATOR_WITH_ROLLBACK_LOG_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define SAWR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define SAWR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/sawr_pkg.sv @@
// Types and constants of the stack allocator with rollback log.
`timescale 1ns / 1ps

package sawr_pkg;

   // Layout constants of the managed region (bytes).
   localparam int unsigned ALIGN_BYTES    = 64;
   localparam int unsigned ALIGN_LSB      = $clog2(ALIGN_BYTES);
   localparam int unsigned HEADER_BYTES   = 64;
   localparam int unsigned RECORD_BYTES   = 32;
   localparam int unsigned TOP_META_BYTES = 64;

   // Depth of the record log.
   localparam int unsigned MAX_RECORDS    = 1024;

   // Fixed field widths.
   localparam int unsigned IDX_W    = 11;
   localparam int unsigned CSR_IDX_W = 1;

   // Operation codes.
   localparam logic [1:0] OP_ALLOC    = 2'd0;
   localparam logic [1:0] OP_ROLLBACK = 2'd1;
   localparam logic [1:0] OP_READ     = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_BAD     = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_START = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_SIZE  = 1'd1;

   // One log record. end_abs is the absolute end of the allocation
   // (data offset + bytes taken - header), mod 2^32.
   typedef struct packed {
      logic [31:0] slot_id;
      logic        old_valid;
      logic [31:0] old_offset;
      logic        data_valid;
      logic [31:0] data_offset;
      logic [31:0] end_abs;
   } rec_type;

   // One result beat.
   typedef struct packed {
      logic [1:0]       status;
      logic [31:0]      alloc_offset;
      logic             alloc_valid;
      logic [IDX_W-1:0] record_count;
      logic [31:0]      rec_slot_id;
      logic [31:0]      rec_old_offset;
      logic             rec_old_valid;
      logic [31:0]      rec_data_offset;
      logic             rec_data_valid;
   } rsp_type;

endpackage

@@ src/sawr_rec_mem.sv @@
// Record log memory: one write port, one registered read port.
`timescale 1ns / 1ps

module sawr_rec_mem #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW    = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  sawr_pkg::rec_type wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output sawr_pkg::rec_type rd_data
);

   sawr_pkg::rec_type store_ff [DEPTH];
   sawr_pkg::rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/stack_allocator_with_rollback_log_top.sv @@
// Top level of the stack allocator with rollback log.
//
//   channel   ports                          handshake
//   -------   -----------------------------  ---------------------------------
//   request   start, busy, req_*             beat taken when start && !busy
//   response  rsp_valid, rsp_*               one-cycle strobe, no back-pressure
//   config    csr_wr_en, csr_index, csr_wdata write when csr_wr_en, no wait
//
// Order: an allocate passes S_EVAL, then S_ALLOC; a read passes S_EVAL,
// which starts the registered record memory read, then S_READ; a request
// rejected up front (bad region, bad argument, no space on size or count)
// responds from S_EVAL. A rollback walks back through the record memory
// from the kept count to the newest allocation record in S_SCAN. The next
// request beat can be taken in the cycle the response is shown. Reset is
// synchronous: it clears the bump pointer, the record count, the config
// registers and the FSM; the record memory is not cleared (entries above
// the count are never read). The receiver cannot stall.
`timescale 1ns / 1ps

module stack_allocator_with_rollback_log_top (
   input  logic                           clock,
   input  logic                           reset,

   // request channel
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_op,
   input  logic [31:0]                    req_slot_id,
   input  logic [31:0]                    req_old_offset,
   input  logic                           req_old_offset_valid,
   input  logic [31:0]                    req_request_size,
   input  logic [sawr_pkg::IDX_W-1:0]     req_record_index,

   // response channel
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic [31:0]                    rsp_alloc_offset,
   output logic                           rsp_alloc_valid,
   output logic [sawr_pkg::IDX_W-1:0]     rsp_record_count,
   output logic [31:0]                    rsp_rec_slot_id,
   output logic [31:0]                    rsp_rec_old_offset,
   output logic                           rsp_rec_old_valid,
   output logic [31:0]                    rsp_rec_data_offset,
   output logic                           rsp_rec_data_valid,

   // config port
   input  logic                           csr_wr_en,
   input  logic [sawr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata
);

   // count holds 0..MAX_RECORDS; memory address covers 0..MAX_RECORDS-1
   localparam int unsigned CW = $clog2(sawr_pkg::MAX_RECORDS + 1);
   localparam int unsigned AW = $clog2(sawr_pkg::MAX_RECORDS);
   // common width for comparing record_index against the count
   localparam int unsigned IW = (CW > sawr_pkg::IDX_W) ? CW : sawr_pkg::IDX_W;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EVAL  = 5'b00010,
      S_ALLOC = 5'b00100,
      S_READ  = 5'b01000,
      S_SCAN  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // config registers
   logic [31:0] region_start_ff, region_size_ff;

   // allocator state
   logic [31:0]   used_ff, used_in;
   logic [CW-1:0] cnt_ff,  cnt_in;

   // latched request beat
   logic [1:0]                 op_ff;
   logic [31:0]                slot_ff, old_ff, reqsz_ff;
   logic                       oldv_ff;
   logic [sawr_pkg::IDX_W-1:0] idx_ff;

   // allocate check stage
   logic [33:0]        take_ff, take_in;
   logic [32:0]        next_ff, next_in;
   logic signed [35:0] limit_ff, limit_in;

   // rollback walk
   logic [CW-1:0] scan_ff, scan_in;
   logic          pend_ff, pend_in;

   // response register
   sawr_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // record memory ports
   logic              mem_wr_en, mem_rd_en;
   logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
   sawr_pkg::rec_type mem_wr_data, mem_rd_data;

   logic accept;

   // combinational helpers
   logic [32:0]        rsum;
   logic               region_ok;
   logic [32:0]        req_rnd;
   logic [33:0]        take_calc;
   logic [CW:0]        cnt_p1;
   logic signed [35:0] limit_calc;
   logic               bad_old;
   logic [35:0]        need;
   logic [32:0]        data_calc;
   logic               scan_hit;
   logic [sawr_pkg::IDX_W-1:0] idx_m1;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   sawr_rec_mem #(
      .DEPTH (sawr_pkg::MAX_RECORDS),
      .AW    (AW)
   ) u_rec_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Region must hold more than the metadata, be aligned and end at or below 2^32.
   assign rsum      = 33'(region_start_ff) + 33'(region_size_ff);
   assign region_ok = (region_size_ff > 32'(sawr_pkg::TOP_META_BYTES))
                   && (region_start_ff[sawr_pkg::ALIGN_LSB-1:0] == '0)
                   && (region_size_ff[sawr_pkg::ALIGN_LSB-1:0] == '0)
                   && (!rsum[32] || (rsum[31:0] == '0));

   // A nonzero size rounded up to the alignment, then the header added on; a zero size takes nothing.
   assign req_rnd   = (33'(reqsz_ff) + 33'(sawr_pkg::ALIGN_BYTES - 1))
                    & ~33'(sawr_pkg::ALIGN_BYTES - 1);
   assign take_calc = (reqsz_ff == '0) ? '0 : 34'(req_rnd) + 34'(sawr_pkg::HEADER_BYTES);
   assign bad_old   = oldv_ff && (old_ff[sawr_pkg::ALIGN_LSB-1:0] != '0);

   // Lowest record address once the new record is in; may go negative.
   assign cnt_p1     = (CW+1)'(cnt_ff) + (CW+1)'(1);
   assign limit_calc = $signed(36'(rsum) - 36'(sawr_pkg::TOP_META_BYTES)
                       - 36'(cnt_p1) * 36'(sawr_pkg::RECORD_BYTES));

   assign need      = 36'(next_ff) + 36'(take_ff);
   assign data_calc = next_ff + 33'(sawr_pkg::HEADER_BYTES);

   assign scan_hit  = pend_ff && mem_rd_data.data_valid;
   assign idx_m1    = idx_ff - sawr_pkg::IDX_W'(1);

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      cnt_in       = cnt_ff;
      take_in      = take_ff;
      next_in      = next_ff;
      limit_in     = limit_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.record_count = sawr_pkg::IDX_W'(cnt_ff);
      mem_wr_en    = 1'b0;
      mem_wr_addr  = AW'(cnt_ff);
      mem_wr_data  = '0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = AW'(idx_m1);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EVAL;
            end
         end

         // Argument checks, and set-up of the op's memory phase.
         S_EVAL: begin
            rsp_in.status = sawr_pkg::ST_BAD;
            if (!region_ok) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               case (op_ff)
                  sawr_pkg::OP_ALLOC: begin
                     if (bad_old || ((reqsz_ff == '0) && !oldv_ff)) begin
                        rsp_valid_in = 1'b1;
                        state_in     = S_IDLE;
                     end else if (((reqsz_ff != '0) && (req_rnd > 33'(region_size_ff)))
                                  || (cnt_ff >= CW'(sawr_pkg::MAX_RECORDS))) begin
                        rsp_in.status = sawr_pkg::ST_NOSPACE;
                        rsp_valid_in  = 1'b1;
                        state_in      = S_IDLE;
                     end else begin
                        take_in  = take_calc;
                        next_in  = 33'(region_start_ff) + 33'(used_ff);
                        limit_in = limit_calc;
                        state_in = S_ALLOC;
                     end
                  end
                  sawr_pkg::OP_ROLLBACK: begin
                     if (IW'(idx_ff) > IW'(cnt_ff)) begin
                        rsp_valid_in = 1'b1;
                        state_in     = S_IDLE;
                     end else begin
                        scan_in  = CW'(idx_ff);
                        state_in = S_SCAN;
                     end
                  end
                  sawr_pkg::OP_READ: begin
                     if ((idx_ff == '0) || (IW'(idx_ff) > IW'(cnt_ff))) begin
                        rsp_valid_in = 1'b1;
                        state_in     = S_IDLE;
                     end else begin
                        mem_rd_en = 1'b1;
                        state_in  = S_READ;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               endcase
            end
         end

         // Collision check against the record area and alignment check of the data offset, then commit.
         S_ALLOC: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if ($signed(need) > limit_ff) begin
               rsp_in.status = sawr_pkg::ST_NOSPACE;
            end else if ((take_ff != '0)
                         && (data_calc[sawr_pkg::ALIGN_LSB-1:0] != '0)) begin
               rsp_in.status = sawr_pkg::ST_BAD;
            end else begin
               mem_wr_en               = 1'b1;
               mem_wr_data.slot_id     = slot_ff;
               mem_wr_data.old_valid   = oldv_ff;
               mem_wr_data.old_offset  = oldv_ff ? old_ff : '0;
               mem_wr_data.data_valid  = (take_ff != '0);
               mem_wr_data.data_offset = (take_ff != '0) ? data_calc[31:0] : '0;
               mem_wr_data.end_abs     = need[31:0];
               cnt_in                  = cnt_ff + CW'(1);
               rsp_in.status           = sawr_pkg::ST_OK;
               rsp_in.record_count     = sawr_pkg::IDX_W'(cnt_p1);
               if (take_ff != '0) begin
                  used_in             = used_ff + take_ff[31:0];
                  rsp_in.alloc_offset = data_calc[31:0];
                  rsp_in.alloc_valid  = 1'b1;
               end
            end
         end

         S_READ: begin
            rsp_valid_in           = 1'b1;
            state_in               = S_IDLE;
            rsp_in.status          = sawr_pkg::ST_OK;
            rsp_in.rec_slot_id     = mem_rd_data.slot_id;
            rsp_in.rec_old_offset  = mem_rd_data.old_offset;
            rsp_in.rec_old_valid   = mem_rd_data.old_valid;
            rsp_in.rec_data_offset = mem_rd_data.data_offset;
            rsp_in.rec_data_valid  = mem_rd_data.data_valid;
         end

         // Walk back one record a cycle; read of the next entry overlaps the
         // check of the one returned from the previous read.
         S_SCAN: begin
            if (scan_hit || (scan_ff == '0)) begin
               used_in             = scan_hit ? (mem_rd_data.end_abs - region_start_ff) : '0;
               cnt_in              = CW'(idx_ff);
               rsp_in.status       = sawr_pkg::ST_OK;
               rsp_in.record_count = idx_ff;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(scan_ff - CW'(1));
               scan_in     = scan_ff - CW'(1);
               pend_in     = 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         used_ff         <= '0;
         cnt_ff          <= '0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         region_start_ff <= '0;
         region_size_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               sawr_pkg::CSR_REGION_START: region_start_ff <= csr_wdata;
               sawr_pkg::CSR_REGION_SIZE:  region_size_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         slot_ff  <= req_slot_id;
         old_ff   <= req_old_offset;
         oldv_ff  <= req_old_offset_valid;
         reqsz_ff <= req_request_size;
         idx_ff   <= req_record_index;
      end
      take_ff  <= take_in;
      next_ff  <= next_in;
      limit_ff <= limit_in;
      scan_ff  <= scan_in;
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_alloc_offset    = rsp_ff.alloc_offset;
   assign rsp_alloc_valid     = rsp_ff.alloc_valid;
   assign rsp_record_count    = rsp_ff.record_count;
   assign rsp_rec_slot_id     = rsp_ff.rec_slot_id;
   assign rsp_rec_old_offset  = rsp_ff.rec_old_offset;
   assign rsp_rec_old_valid   = rsp_ff.rec_old_valid;
   assign rsp_rec_data_offset = rsp_ff.rec_data_offset;
   assign rsp_rec_data_valid  = rsp_ff.rec_data_valid;

endmodule

@@ src/sawr_checker.sv @@
// Port-level checker for the stack allocator top, bound to the top level.
`timescale 1ns / 1ps
`include "stack_allocator_with_rollback_log_top_macros.svh"

module sawr_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic       rsp_alloc_valid,
   input logic       rsp_rec_data_valid
);

   // a request beat always makes the block busy in the next cycle
   `SAWR_ASSERT_NXT(a_accept_busy, start && !busy, busy, "no busy after request beat")

   // the response beat comes out as the block goes idle
   `SAWR_ASSERT_IMP(a_rsp_idle, rsp_valid, !busy, "response beat while busy")

   // one beat per request; never two in a row
   `SAWR_ASSERT_NXT(a_rsp_single, rsp_valid, !rsp_valid, "response strobe held two cycles")

   // allocation or record fields only on success
   `SAWR_ASSERT_IMP(a_ok_fields, rsp_valid && (rsp_alloc_valid || rsp_rec_data_valid),
      rsp_status == sawr_pkg::ST_OK, "payload flags set on a failed request")

endmodule

bind stack_allocator_with_rollback_log_top sawr_checker u_sawr_checker (.*);
